>>> src/pcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcf_pkg
// Types, codes and constants of the pixel color filter.
// ----------------------------------------------------------------------------
package pcf_pkg;

   localparam int ChanWidth  = 8;
   localparam int DataWidth  = 16;
   localparam int IndexWidth = 3;

   typedef struct packed {
      logic [ChanWidth-1:0] red;
      logic [ChanWidth-1:0] green;
      logic [ChanWidth-1:0] blue;
   } pixel_type;

   typedef enum logic [2:0] {
      MODE_GRAY        = 3'd0,
      MODE_NEGATIVE    = 3'd1,
      MODE_SEPIA       = 3'd2,
      MODE_BRIGHTNESS  = 3'd3,
      MODE_CONTRAST    = 3'd4,
      MODE_THRESHOLD   = 3'd5,
      MODE_BOOST       = 3'd6,
      MODE_TEMPERATURE = 3'd7
   } filter_mode_type;

   typedef enum logic [IndexWidth-1:0] {
      REG_FILTER_MODE      = 3'd0,
      REG_BRIGHTNESS_DELTA = 3'd1,
      REG_CONTRAST_GAIN    = 3'd2,
      REG_BOOST_CHANNEL    = 3'd3,
      REG_RED_SHIFT        = 3'd4,
      REG_BLUE_SHIFT       = 3'd5,
      REG_THRESHOLD_LEVEL  = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      CHAN_BLUE  = 2'd0,
      CHAN_GREEN = 2'd1,
      CHAN_RED   = 2'd2,
      CHAN_NONE  = 2'd3
   } channel_type;

   // luma weights
   localparam logic [9:0] LUMA_R = 10'd299;
   localparam logic [9:0] LUMA_G = 10'd587;
   localparam logic [9:0] LUMA_B = 10'd114;

   // sepia matrix
   localparam logic [9:0] SEP_RR = 10'd393;
   localparam logic [9:0] SEP_RG = 10'd769;
   localparam logic [9:0] SEP_RB = 10'd189;
   localparam logic [9:0] SEP_GR = 10'd349;
   localparam logic [9:0] SEP_GG = 10'd686;
   localparam logic [9:0] SEP_GB = 10'd168;
   localparam logic [9:0] SEP_BR = 10'd272;
   localparam logic [9:0] SEP_BG = 10'd534;
   localparam logic [9:0] SEP_BB = 10'd131;

   // floor(x / 1000) = (x * ceil(2^29 / 1000)) >> 29, exact for x < 2^19
   localparam int          DivShift = 29;
   localparam logic [19:0] DIV_MUL  = 20'd536871;

   localparam logic signed [25:0] CON_OFFSET = 26'sd32768;
   localparam logic signed [9:0]  CON_MID    = 10'sd128;

   localparam logic [2:0]            RST_FILTER_MODE = 3'd0;
   localparam logic signed [8:0]     RST_BRIGHTNESS  = 9'sd77;
   localparam logic [DataWidth-1:0]  RST_GAIN        = 16'd384;
   localparam logic [1:0]            RST_BOOST       = 2'd2;
   localparam logic signed [8:0]     RST_RED_SHIFT   = 9'sd40;
   localparam logic signed [8:0]     RST_BLUE_SHIFT  = -9'sd40;
   localparam logic [ChanWidth-1:0]  RST_THRESHOLD   = 8'd128;

endpackage

>>> src/pixel_color_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_color_filter
// Point color filter on a stream of blue, green, red pixels.
// ----------------------------------------------------------------------------
// One pixel in, one filtered pixel out, at a sustained rate of one transfer
// per clock while the result side accepts. The datapath is three register
// stages: constant-weight products and the contrast multiply, then the
// divide by 1000 done as a reciprocal multiply together with the sepia and
// contrast clamps, then mode selection and final clamping into the output
// register. A result-side stall holds every stage in place and nothing is
// dropped. The csr registers feed the datapath directly; the user writes them
// only while no pixel is in flight, which the block does not enforce.
module pixel_color_filter
   import pcf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // blue_in, green_in, red_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // blue_out, green_out, red_out
   input  logic                  csr_wr_en,
   input  logic [IndexWidth-1:0] csr_index,
   input  logic [DataWidth-1:0]  csr_wdata
);

   // csr registers
   filter_mode_type       filter_mode_ff;
   logic signed [8:0]     brightness_delta_ff;
   logic [DataWidth-1:0]  contrast_gain_ff;
   logic [1:0]            boost_channel_ff;
   logic signed [8:0]     red_shift_ff;
   logic signed [8:0]     blue_shift_ff;
   logic [ChanWidth-1:0]  threshold_level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         filter_mode_ff      <= filter_mode_type'(RST_FILTER_MODE);
         brightness_delta_ff <= RST_BRIGHTNESS;
         contrast_gain_ff    <= RST_GAIN;
         boost_channel_ff    <= RST_BOOST;
         red_shift_ff        <= RST_RED_SHIFT;
         blue_shift_ff       <= RST_BLUE_SHIFT;
         threshold_level_ff  <= RST_THRESHOLD;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            REG_FILTER_MODE:      filter_mode_ff      <= filter_mode_type'(csr_wdata[2:0]);
            REG_BRIGHTNESS_DELTA: brightness_delta_ff <= $signed(csr_wdata[8:0]);
            REG_CONTRAST_GAIN:    contrast_gain_ff    <= csr_wdata;
            REG_BOOST_CHANNEL:    boost_channel_ff    <= csr_wdata[1:0];
            REG_RED_SHIFT:        red_shift_ff        <= $signed(csr_wdata[8:0]);
            REG_BLUE_SHIFT:       blue_shift_ff       <= $signed(csr_wdata[8:0]);
            REG_THRESHOLD_LEVEL:  threshold_level_ff  <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   function automatic logic [9:0] div1000(input logic [18:0] x);
      logic [38:0] p;
      p = 39'(x) * 39'(DIV_MUL);
      return p[38:DivShift];
   endfunction

   function automatic logic [7:0] clamp_s11(input logic signed [10:0] v);
      logic [7:0] r;
      if (v[10]) r = 8'd0;
      else if (v[9:8] != 2'b00) r = 8'hFF;
      else r = v[7:0];
      return r;
   endfunction

   function automatic logic signed [25:0] con_term(input logic [7:0] x,
                                                   input logic [DataWidth-1:0] g);
      logic signed [9:0] d;
      d = $signed({2'b00, x}) - CON_MID;
      return CON_OFFSET + 26'($signed({1'b0, g})) * 26'(d);
   endfunction

   function automatic logic [7:0] con_clamp(input logic signed [25:0] t);
      logic [7:0] r;
      if (t[25]) r = 8'd0;
      else if (t[24:16] != '0) r = 8'hFF;
      else r = t[15:8];
      return r;
   endfunction

   // handshake chain
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready   = !s3_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_tvalid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   // stage 1: weighted sums and contrast products
   pixel_type         px_in;
   pixel_type         s1_pix_ff;
   logic [18:0]       s1_luma_in, s1_luma_ff;
   logic [18:0]       s1_sep_r_in, s1_sep_r_ff;
   logic [18:0]       s1_sep_g_in, s1_sep_g_ff;
   logic [18:0]       s1_sep_b_in, s1_sep_b_ff;
   logic signed [25:0] s1_con_r_in, s1_con_r_ff;
   logic signed [25:0] s1_con_g_in, s1_con_g_ff;
   logic signed [25:0] s1_con_b_in, s1_con_b_ff;

   assign px_in = pixel_type'(req_tdata);

   always_comb begin
      s1_luma_in  = 19'(LUMA_R) * 19'(px_in.red) + 19'(LUMA_G) * 19'(px_in.green)
                  + 19'(LUMA_B) * 19'(px_in.blue);
      s1_sep_r_in = 19'(SEP_RR) * 19'(px_in.red) + 19'(SEP_RG) * 19'(px_in.green)
                  + 19'(SEP_RB) * 19'(px_in.blue);
      s1_sep_g_in = 19'(SEP_GR) * 19'(px_in.red) + 19'(SEP_GG) * 19'(px_in.green)
                  + 19'(SEP_GB) * 19'(px_in.blue);
      s1_sep_b_in = 19'(SEP_BR) * 19'(px_in.red) + 19'(SEP_BG) * 19'(px_in.green)
                  + 19'(SEP_BB) * 19'(px_in.blue);
      s1_con_r_in = con_term(px_in.red, contrast_gain_ff);
      s1_con_g_in = con_term(px_in.green, contrast_gain_ff);
      s1_con_b_in = con_term(px_in.blue, contrast_gain_ff);
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_pix_ff   <= px_in;
         s1_luma_ff  <= s1_luma_in;
         s1_sep_r_ff <= s1_sep_r_in;
         s1_sep_g_ff <= s1_sep_g_in;
         s1_sep_b_ff <= s1_sep_b_in;
         s1_con_r_ff <= s1_con_r_in;
         s1_con_g_ff <= s1_con_g_in;
         s1_con_b_ff <= s1_con_b_in;
      end
   end

   // stage 2: divide by 1000, clamp sepia and contrast
   pixel_type  s2_pix_ff;
   logic [9:0] q_luma, q_sep_r, q_sep_g, q_sep_b;
   logic [7:0] s2_luma_in, s2_luma_ff;
   pixel_type  s2_sepia_in, s2_sepia_ff;
   pixel_type  s2_con_in, s2_con_ff;

   always_comb begin
      q_luma            = div1000(s1_luma_ff);
      q_sep_r           = div1000(s1_sep_r_ff);
      q_sep_g           = div1000(s1_sep_g_ff);
      q_sep_b           = div1000(s1_sep_b_ff);
      s2_luma_in        = q_luma[7:0];
      s2_sepia_in.red   = (q_sep_r[9:8] != 2'b00) ? 8'hFF : q_sep_r[7:0];
      s2_sepia_in.green = (q_sep_g[9:8] != 2'b00) ? 8'hFF : q_sep_g[7:0];
      s2_sepia_in.blue  = (q_sep_b[9:8] != 2'b00) ? 8'hFF : q_sep_b[7:0];
      s2_con_in.red     = con_clamp(s1_con_r_ff);
      s2_con_in.green   = con_clamp(s1_con_g_ff);
      s2_con_in.blue    = con_clamp(s1_con_b_ff);
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_pix_ff   <= s1_pix_ff;
         s2_luma_ff  <= s2_luma_in;
         s2_sepia_ff <= s2_sepia_in;
         s2_con_ff   <= s2_con_in;
      end
   end

   // stage 3: mode select and output register
   pixel_type  s3_out_in, s3_out_ff;
   logic [7:0] thr_val;
   logic [9:0] boost_r, boost_g, boost_b;

   function automatic logic [7:0] boost_one(input logic [7:0] x, input logic sel);
      logic [9:0] t;
      logic [7:0] r;
      t = 10'(x) * 10'd3;
      if (!sel) r = x >> 1;
      else if (t[9]) r = 8'hFF;
      else r = t[8:1];
      return r;
   endfunction

   always_comb begin
      thr_val = (s2_luma_ff >= threshold_level_ff) ? 8'hFF : 8'h00;
      boost_r = '0;
      boost_g = '0;
      boost_b = '0;
      s3_out_in = s2_pix_ff;
      case (filter_mode_ff)
         MODE_GRAY: begin
            s3_out_in = '{red: s2_luma_ff, green: s2_luma_ff, blue: s2_luma_ff};
         end
         MODE_NEGATIVE: begin
            s3_out_in = ~s2_pix_ff;
         end
         MODE_SEPIA: begin
            s3_out_in = s2_sepia_ff;
         end
         MODE_BRIGHTNESS: begin
            s3_out_in.red   = clamp_s11($signed({3'b000, s2_pix_ff.red})
                                        + 11'(brightness_delta_ff));
            s3_out_in.green = clamp_s11($signed({3'b000, s2_pix_ff.green})
                                        + 11'(brightness_delta_ff));
            s3_out_in.blue  = clamp_s11($signed({3'b000, s2_pix_ff.blue})
                                        + 11'(brightness_delta_ff));
         end
         MODE_CONTRAST: begin
            s3_out_in = s2_con_ff;
         end
         MODE_THRESHOLD: begin
            s3_out_in = '{red: thr_val, green: thr_val, blue: thr_val};
         end
         MODE_BOOST: begin
            boost_r = 10'(boost_one(s2_pix_ff.red,
                                    channel_type'(boost_channel_ff) == CHAN_RED));
            boost_g = 10'(boost_one(s2_pix_ff.green,
                                    channel_type'(boost_channel_ff) == CHAN_GREEN));
            boost_b = 10'(boost_one(s2_pix_ff.blue,
                                    channel_type'(boost_channel_ff) == CHAN_BLUE));
            s3_out_in = '{red: boost_r[7:0], green: boost_g[7:0], blue: boost_b[7:0]};
         end
         MODE_TEMPERATURE: begin
            s3_out_in.red  = clamp_s11($signed({3'b000, s2_pix_ff.red})
                                       + 11'(red_shift_ff));
            s3_out_in.blue = clamp_s11($signed({3'b000, s2_pix_ff.blue})
                                       + 11'(blue_shift_ff));
         end
         default: s3_out_in = s2_pix_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_out_ff <= s3_out_in;
      end
   end

   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = s3_out_ff;

endmodule
